// File: rtl/saso_pkg.sv
// Shared constants and types for the small array set-operation block.
// Holds operation codes, step kinds and the read-step tag.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package saso_pkg;

  // Default number of elements each array can hold
  localparam int unsigned SASO_CAPACITY = 8;
  // Element and result width
  localparam int unsigned VALUE_W = 32;
  // Operation register width
  localparam int unsigned OP_W = 2;

  // Operation codes held in the configuration register
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ISECT = 2'd1;
  localparam logic [OP_W-1:0] OP_UNION = 2'd2;

  // What to do with one pair of words read from the stores
  typedef enum logic [1:0] {
    K_ADD,    // push first + second (second masked when past its length)
    K_ISECT,  // push first when the pair is equal
    K_PASS,   // push first as is
    K_UNB     // scan first array for a second-array word
  } step_kind_e;

  // Tag that travels alongside one memory read
  typedef struct packed {
    logic       valid;
    step_kind_e kind;
    logic       b_ok;        // second word lies inside the loaded length
    logic       a_ok;        // first word lies inside the loaded length
    logic       last_inner;  // last first-array word for this second word
  } step_tag_t;

endpackage

`default_nettype wire

// File: rtl/small_array_set_operation.sv
// Top level of the small array set-operation block: load, sequencer, result output.
// Two element stores with registered reads hold both arrays.
// Depends on saso_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Load words with start high while busy is low: side_i picks the array,
//   final_req_i on a second-array word closes the run. Words past CAPACITY
//   are dropped and flagged.
//   The closing word raises busy. The sequencer then walks the stores, one
//   read pair per cycle, and gives at most one result per cycle:
//     add:          F steps
//     intersection: F * S steps
//     union:        F + S * max(F, 1) steps
//   (F, S = loaded lengths), plus the dispatch, drain and final states; a
//   run with no steps skips the drain. Cost is set by the single
//   read port of each store.
//   Results come out on result_valid_o, one word per strobe; result_last_o
//   marks the last word, empty_res_o marks a run with no elements.
//   busy drops in the cycle the last word is shown, so the next word can be
//   loaded then. The receiver cannot stall; every strobe is taken. cfg_we_i
//   writes the operation register; the user must write it only while idle,
//   not enforced by the block. Reset clears counts, drop flag, operation and
//   all control; stores are not cleared, only loaded entries are ever used.
module small_array_set_operation
  import saso_pkg::*;
#(
  parameter int unsigned CAPACITY = SASO_CAPACITY
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      side_i,
  input  wire logic signed [VALUE_W-1:0] value_i,
  input  wire logic                      final_req_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [OP_W-1:0]           cfg_wdata_i,
  output logic                           result_valid_o,
  output logic signed [VALUE_W-1:0]      result_value_o,
  output logic                           result_last_o,
  output logic                           empty_res_o,
  output logic                           overflowed_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);
  localparam logic [CntW-1:0] One    = CntW'(1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_ISECT = 3'd3;
  localparam logic [2:0] S_UA    = 3'd4;
  localparam logic [2:0] S_UB    = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_FINAL = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [OP_W-1:0]       op_q;
  logic [CntW-1:0]       fc_q, fc_d, sc_q, sc_d;
  logic [CntW-1:0]       i_q, i_d, j_q, j_d;
  logic                  drop_q, drop_d;
  logic                  found_q, found_d;
  logic                  pend_valid_q, pend_valid_d;
  logic signed [VALUE_W-1:0] pend_value_q, pend_value_d;
  step_tag_t             tag_q, tag_d;

  logic signed [VALUE_W-1:0] first_mem [CAPACITY];
  logic signed [VALUE_W-1:0] second_mem [CAPACITY];
  logic signed [VALUE_W-1:0] rd_a_q, rd_b_q;
  logic [IdxW-1:0]       addr_a, addr_b;
  logic                  wr_a, wr_b;

  logic                  accept;
  logic                  end_inner;
  logic                  push, hit;
  logic signed [VALUE_W-1:0] push_val;

  logic                  emit_valid, emit_last, emit_empty;
  logic signed [VALUE_W-1:0] emit_value;
  logic                  out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                  out_last_q, out_empty_q, out_ovf_q;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Hold the operation register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_ADD;
    end else if (cfg_we_i) begin
      op_q <= cfg_wdata_i;
    end
  end

  // Load words and sequence the read steps
  always_comb begin
    state_d   = state_q;
    fc_d      = fc_q;
    sc_d      = sc_q;
    i_d       = i_q;
    j_d       = j_q;
    drop_d    = drop_q;
    wr_a      = 1'b0;
    wr_b      = 1'b0;
    addr_a    = i_q[IdxW-1:0];
    addr_b    = i_q[IdxW-1:0];
    end_inner = 1'b0;
    tag_d     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!side_i) begin
            if (fc_q < CapCnt) begin
              wr_a = 1'b1;
              fc_d = fc_q + One;
            end else begin
              drop_d = 1'b1;
            end
          end else begin
            if (sc_q < CapCnt) begin
              wr_b = 1'b1;
              sc_d = sc_q + One;
            end else begin
              drop_d = 1'b1;
            end
            if (final_req_i) begin
              state_d = S_START;
            end
          end
        end
      end
      S_START: begin
        i_d = '0;
        j_d = '0;
        unique case (op_q)
          OP_ADD:   state_d = (fc_q != '0) ? S_ADD : S_FINAL;
          OP_ISECT: state_d = (fc_q != '0 && sc_q != '0) ? S_ISECT : S_FINAL;
          OP_UNION: begin
            if (fc_q != '0) begin
              state_d = S_UA;
            end else begin
              state_d = (sc_q != '0) ? S_UB : S_FINAL;
            end
          end
          default:  state_d = S_FINAL;
        endcase
      end
      S_ADD: begin
        tag_d.valid = 1'b1;
        tag_d.kind  = K_ADD;
        tag_d.b_ok  = (i_q < sc_q);
        i_d = i_q + One;
        if (i_q == fc_q - One) begin
          state_d = S_DRAIN;
        end
      end
      S_ISECT: begin
        addr_b      = j_q[IdxW-1:0];
        tag_d.valid = 1'b1;
        tag_d.kind  = K_ISECT;
        if (j_q == sc_q - One) begin
          j_d = '0;
          i_d = i_q + One;
          if (i_q == fc_q - One) begin
            state_d = S_DRAIN;
          end
        end else begin
          j_d = j_q + One;
        end
      end
      S_UA: begin
        tag_d.valid = 1'b1;
        tag_d.kind  = K_PASS;
        i_d = i_q + One;
        if (i_q == fc_q - One) begin
          i_d     = '0;
          state_d = (sc_q != '0) ? S_UB : S_DRAIN;
        end
      end
      S_UB: begin
        // i walks the second array, j scans the first
        addr_b           = i_q[IdxW-1:0];
        addr_a           = j_q[IdxW-1:0];
        end_inner        = (fc_q == '0) || (j_q == fc_q - One);
        tag_d.valid      = 1'b1;
        tag_d.kind       = K_UNB;
        tag_d.a_ok       = (fc_q != '0);
        tag_d.last_inner = end_inner;
        if (end_inner) begin
          j_d = '0;
          i_d = i_q + One;
          if (i_q == sc_q - One) begin
            state_d = S_DRAIN;
          end
        end else begin
          j_d = j_q + One;
        end
      end
      S_DRAIN: begin
        state_d = S_FINAL;
      end
      S_FINAL: begin
        state_d = S_IDLE;
        fc_d    = '0;
        sc_d    = '0;
        drop_d  = 1'b0;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Element stores; writes happen only while loading and read data is used
  // only while computing, so a write never meets a read whose data is used
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      first_mem[fc_q[IdxW-1:0]] <= value_i;
    end
    if (wr_b) begin
      second_mem[sc_q[IdxW-1:0]] <= value_i;
    end
    rd_a_q <= first_mem[addr_a];
    rd_b_q <= second_mem[addr_b];
  end

  // Evaluate the pair that came back from the stores
  always_comb begin
    push     = 1'b0;
    push_val = rd_a_q;
    found_d  = found_q;
    hit      = tag_q.a_ok && (rd_a_q == rd_b_q);
    if (tag_q.valid) begin
      unique case (tag_q.kind)
        K_ADD: begin
          push     = 1'b1;
          push_val = rd_a_q + (tag_q.b_ok ? rd_b_q : '0);
        end
        K_ISECT: push = (rd_a_q == rd_b_q);
        K_PASS:  push = 1'b1;
        K_UNB: begin
          if (tag_q.last_inner) begin
            push     = !(found_q || hit);
            push_val = rd_b_q;
            found_d  = 1'b0;
          end else begin
            found_d  = found_q || hit;
          end
        end
        default: push = 1'b0;
      endcase
    end
  end

  // Keep one result back so the last word can be marked
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_value_d = pend_value_q;
    emit_valid   = 1'b0;
    emit_last    = 1'b0;
    emit_empty   = 1'b0;
    emit_value   = pend_value_q;
    if (state_q == S_FINAL) begin
      emit_valid   = 1'b1;
      emit_last    = 1'b1;
      emit_empty   = !pend_valid_q;
      emit_value   = pend_valid_q ? pend_value_q : '0;
      pend_valid_d = 1'b0;
    end else if (push) begin
      emit_valid   = pend_valid_q;
      pend_valid_d = 1'b1;
      pend_value_d = push_val;
    end
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fc_q         <= '0;
      sc_q         <= '0;
      i_q          <= '0;
      j_q          <= '0;
      drop_q       <= 1'b0;
      found_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      tag_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fc_q         <= fc_d;
      sc_q         <= sc_d;
      i_q          <= i_d;
      j_q          <= j_d;
      drop_q       <= drop_d;
      found_q      <= found_d;
      pend_valid_q <= pend_valid_d;
      tag_q        <= tag_d;
      out_valid_q  <= emit_valid;
    end
  end

  // Register the result word
  always_ff @(posedge clk_i) begin
    pend_value_q <= pend_value_d;
    if (emit_valid) begin
      out_value_q <= emit_value;
      out_last_q  <= emit_last;
      out_empty_q <= emit_empty;
      out_ovf_q   <= drop_q;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_value_o = out_value_q;
  assign result_last_o  = out_last_q;
  assign empty_res_o    = out_empty_q;
  assign overflowed_o   = out_ovf_q;

  // The last word of a run is shown only once the block is free again
  a_last_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_last_o |-> !busy)
    else $error("last result shown while still busy");

  // An empty answer is always the only and last word
  a_empty_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && empty_res_o |-> result_last_o)
    else $error("empty result not marked last");

  // Loaded lengths never pass the capacity
  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= CapCnt && sc_q <= CapCnt)
    else $error("array count beyond capacity");

  // A closing word always starts a computation
  a_close_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && side_i && final_req_i |=> busy)
    else $error("closing word did not start the run");

endmodule

`default_nettype wire

// File: tb/small_array_set_operation_test.sv
// Self-checking bench for small_array_set_operation: add, intersection, union, spare runs.
// Directed table, then random runs; each word checked against a predictor or the table.
// Depends on saso_pkg and the small_array_set_operation RTL.
`timescale 1ns / 1ps

module small_array_set_operation_test;
  import saso_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 6;
  localparam int RANDOM_WORDS   = 200;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;
  localparam int DIR_N          = 16;

  // Selector value with no operation behind it
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // One result word as seen on the output ports
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               empty;
    logic               ovf;
  } set_word_t;

  // One row of the directed table; want is used only where typed is set
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               side;
    logic [VALUE_W-1:0] value;
    logic               fin;
    logic [3:0]         reps;
    logic               typed;
    set_word_t          want;
  } stim_row_t;

  localparam set_word_t NO_WORD = '0;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      side_i = 1'b0;
  logic signed [VALUE_W-1:0] value_i = '0;
  logic                      final_req_i = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [OP_W-1:0]           cfg_wdata_i = '0;
  logic                      result_valid_o;
  logic signed [VALUE_W-1:0] result_value_o;
  logic                      result_last_o;
  logic                      empty_res_o;
  logic                      overflowed_o;

  // Predictor state: loaded arrays, lengths, drop flag and operation
  logic [VALUE_W-1:0] first_store [SASO_CAPACITY];
  logic [VALUE_W-1:0] second_store [SASO_CAPACITY];
  int unsigned        first_len = 0;
  int unsigned        second_len = 0;
  logic               dropped = 1'b0;
  logic [OP_W-1:0]    cur_op = OP_ADD;

  set_word_t          computed_words [$];
  set_word_t          expected_words [$];
  logic [VALUE_W-1:0] value_pool [4];
  int                 burst_left = 0;
  int                 mismatch_count = 0;
  int                 quiet_cycles = 0;

  stim_row_t stim_rows [DIR_N] = '{
    // nothing loaded in the first array: add gives the empty answer
    '{OP_ADD, 1'b1, 32'd5, 1'b1, 4'd1, 1'b1, '{32'd0, 1'b1, 1'b1, 1'b0}},
    // largest plus one wraps to the most negative value
    '{OP_ADD, 1'b0, 32'h7FFF_FFFF, 1'b0, 4'd1, 1'b0, NO_WORD},
    '{OP_ADD, 1'b1, 32'd1, 1'b1, 4'd1, 1'b1, '{32'h8000_0000, 1'b1, 1'b0, 1'b0}},
    // final request on a first-array word does not close the run; short second array reads as zero
    '{OP_ADD, 1'b0, 32'h8000_0000, 1'b1, 4'd1, 1'b0, NO_WORD},
    '{OP_ADD, 1'b0, 32'hFFFF_FFFF, 1'b0, 4'd1, 1'b0, NO_WORD},
    '{OP_ADD, 1'b1, 32'h8000_0000, 1'b1, 4'd1, 1'b0, NO_WORD},
    // second array full: the closing word is dropped but still closes
    '{OP_ISECT, 1'b0, 32'd3, 1'b0, 4'd1, 1'b0, NO_WORD},
    '{OP_ISECT, 1'b1, 32'd4, 1'b0, 4'd8, 1'b0, NO_WORD},
    '{OP_ISECT, 1'b1, 32'd3, 1'b1, 4'd1, 1'b1, '{32'd0, 1'b1, 1'b1, 1'b1}},
    // union over the value extremes
    '{OP_UNION, 1'b0, 32'h8000_0000, 1'b0, 4'd1, 1'b0, NO_WORD},
    '{OP_UNION, 1'b0, 32'h7FFF_FFFF, 1'b1, 4'd1, 1'b0, NO_WORD},
    '{OP_UNION, 1'b1, 32'h7FFF_FFFF, 1'b0, 4'd1, 1'b0, NO_WORD},
    '{OP_UNION, 1'b1, 32'd0, 1'b1, 4'd1, 1'b0, NO_WORD},
    // union with an empty first array passes the second array through
    '{OP_UNION, 1'b1, 32'd5, 1'b1, 4'd1, 1'b1, '{32'd5, 1'b1, 1'b0, 1'b0}},
    // unused selector gives the empty answer
    '{OP_SPARE, 1'b0, 32'd1, 1'b0, 4'd1, 1'b0, NO_WORD},
    '{OP_SPARE, 1'b1, 32'd1, 1'b1, 4'd1, 1'b1, '{32'd0, 1'b1, 1'b1, 1'b0}}
  };

  small_array_set_operation u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .side_i         (side_i),
    .value_i        (value_i),
    .final_req_i    (final_req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_value_o (result_value_o),
    .result_last_o  (result_last_o),
    .empty_res_o    (empty_res_o),
    .overflowed_o   (overflowed_o)
  );

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // Load one word into the predicted arrays; on a closing word compute the set result
  task automatic predict_word(input logic side, input logic [VALUE_W-1:0] value,
                              input logic fin);
    logic [VALUE_W-1:0] outs [$];
    logic               seen;
    computed_words.delete();
    if (!side) begin
      if (first_len < SASO_CAPACITY) begin
        first_store[first_len] = value;
        first_len++;
      end else begin
        dropped = 1'b1;
      end
      return;
    end
    if (second_len < SASO_CAPACITY) begin
      second_store[second_len] = value;
      second_len++;
    end else begin
      dropped = 1'b1;
    end
    if (!fin) return;

    case (cur_op)
      OP_ADD: begin
        for (int i = 0; i < first_len; i++)
          outs.push_back(first_store[i] + ((i < second_len) ? second_store[i] : '0));
      end
      OP_ISECT: begin
        for (int i = 0; i < first_len; i++)
          for (int j = 0; j < second_len; j++)
            if (first_store[i] == second_store[j]) outs.push_back(first_store[i]);
      end
      OP_UNION: begin
        for (int i = 0; i < first_len; i++) outs.push_back(first_store[i]);
        for (int i = 0; i < second_len; i++) begin
          seen = 1'b0;
          for (int j = 0; j < first_len; j++)
            if (second_store[i] == first_store[j]) seen = 1'b1;
          if (!seen) outs.push_back(second_store[i]);
        end
      end
      default: ;
    endcase

    if (outs.size() == 0) begin
      computed_words.push_back('{'0, 1'b1, 1'b1, dropped});
    end else begin
      foreach (outs[i])
        computed_words.push_back('{outs[i], i == outs.size() - 1, 1'b0, dropped});
    end
    first_len = 0;
    second_len = 0;
    dropped = 1'b0;
  endtask

  // Drop start and keep it low
  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Offer one word, wait for the block to take it, then queue what it should give back
  task automatic send_word(input logic side, input logic [VALUE_W-1:0] value, input logic fin,
                           input logic typed, input set_word_t typed_word);
    if (burst_left == 0) begin
      hold_off($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk_i);
    start       <= 1'b1;
    side_i      <= side;
    value_i     <= value;
    final_req_i <= fin;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_word(side, value, fin);
    if (typed) begin
      computed_words.delete();
      computed_words.push_back(typed_word);
    end
    foreach (computed_words[i]) expected_words.push_back(computed_words[i]);
  endtask

  // Wait until the block is idle, then write the operation register
  task automatic write_op(input logic [OP_W-1:0] op);
    hold_off(1);
    while (expected_words.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= op;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_op = op;
  endtask

  // Favor the run's pool so that equal pairs turn up often
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return value_pool[$urandom_range(0, 3)];
      5:             return '0;
      6:             return '1;
      7:             return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default:       return $urandom;
    endcase
  endfunction

  // Mostly short arrays, sometimes full, now and then past capacity
  function automatic int pick_len(input int lo);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(lo, 4);
    if (r < 9) return $urandom_range(5, SASO_CAPACITY);
    return $urandom_range(SASO_CAPACITY + 1, SASO_CAPACITY + 2);
  endfunction

  // Compare each result word against the oldest expected word
  always @(posedge clk_i) begin : check_results
    set_word_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result word: value %h last %0b empty %0b ovf %0b",
                   result_value_o, result_last_o, empty_res_o, overflowed_o);
      end else begin
        want = expected_words.pop_front();
        if (want.value !== result_value_o || want.last !== result_last_o ||
            want.empty !== empty_res_o || want.ovf !== overflowed_o) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"result mismatch: expected value %h last %0b empty %0b ovf %0b,",
                      " got value %h last %0b empty %0b ovf %0b"},
                     want.value, want.last, want.empty, want.ovf,
                     result_value_o, result_last_o, empty_res_o, overflowed_o);
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || cfg_we_i) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int               random_words;
    int               phase;
    int               n_runs;
    int               f_left;
    int               s_left;
    int               r;
    logic [OP_W-1:0]  phase_op;

    random_words = 0;
    phase = 0;

    // Hold reset, then release on a falling edge
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_op(OP_ADD);

    // Walk the directed table
    for (int row = 0; row < DIR_N; row++) begin
      if (stim_rows[row].op != cur_op) write_op(stim_rows[row].op);
      repeat (stim_rows[row].reps)
        send_word(stim_rows[row].side, stim_rows[row].value, stim_rows[row].fin,
                  stim_rows[row].typed, stim_rows[row].want);
    end

    // Random runs, grouped in phases of one operation each
    while (random_words < RANDOM_WORDS) begin
      case (phase)
        0: phase_op = OP_ADD;
        1: phase_op = OP_ISECT;
        2: phase_op = OP_UNION;
        3: phase_op = OP_SPARE;
        default: begin
          r = $urandom_range(0, 9);
          phase_op = (r < 3) ? OP_ADD : (r < 6) ? OP_ISECT : (r < 9) ? OP_UNION : OP_SPARE;
        end
      endcase
      write_op(phase_op);
      n_runs = $urandom_range(3, 6);
      repeat (n_runs) begin
        f_left = pick_len(0);
        s_left = pick_len(1) - 1;
        value_pool[0] = $urandom;
        value_pool[1] = $urandom;
        value_pool[2] = $urandom_range(0, 3);
        value_pool[3] = -$urandom_range(1, 3);
        // Interleave both arrays, then close on the second
        while (f_left + s_left > 0) begin
          if ($urandom_range(1, f_left + s_left) <= f_left) begin
            send_word(1'b0, pick_value(), $urandom_range(0, 1), 1'b0, NO_WORD);
            f_left--;
          end else begin
            send_word(1'b1, pick_value(), 1'b0, 1'b0, NO_WORD);
            s_left--;
          end
          random_words++;
        end
        send_word(1'b1, pick_value(), 1'b1, 1'b0, NO_WORD);
        random_words++;
      end
      phase++;
    end

    // Drain outstanding results, then let the block settle
    hold_off(1);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
